// ===== hw/rtl/mjs_pkg.sv =====
package mjs_pkg;

	localparam int CORES_DEF  = 8;
	localparam int QDEPTH_DEF = 64;

	localparam logic [1:0] OP_ARRIVE  = 2'd0;
	localparam logic [1:0] OP_FINISH  = 2'd1;
	localparam logic [1:0] OP_QUANTUM = 2'd2;
	localparam logic [1:0] OP_NONE    = 2'd3;

	localparam logic [2:0] MODE_FCFS = 3'd0;
	localparam logic [2:0] MODE_SJF  = 3'd1;
	localparam logic [2:0] MODE_PSJF = 3'd2;
	localparam logic [2:0] MODE_PRI  = 3'd3;
	localparam logic [2:0] MODE_PPRI = 3'd4;
	localparam logic [2:0] MODE_RR   = 3'd5;

	localparam logic REG_MODE  = 1'b0;
	localparam logic REG_CORES = 1'b1;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] job_id;
		logic [31:0] current_time;
		logic [15:0] run_length;
		logic [7:0]  job_priority;
		logic [2:0]  core_index;
	} request_t;

	typedef struct packed {
		logic        scheduled;
		logic [2:0]  target_core;
		logic [15:0] started_job;
		logic        queue_overflow;
		logic [31:0] total_waiting;
		logic [31:0] total_turnaround;
		logic [31:0] total_response;
		logic [15:0] finished_count;
	} result_t;

	// enq holds the start time when the record sits in the core table
	typedef struct packed {
		logic [15:0] num;
		logic [31:0] arr;
		logic [15:0] rem;
		logic [7:0]  urg;
		logic [31:0] enq;
		logic [31:0] first;
		logic        started;
	} job_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH, S_VS_RD, S_VS_CMP, S_ARR_DEC, S_SRCH, S_SRCH_CMP,
		S_SRCH_END, S_SHIFT, S_SHIFT_WR, S_INS_WR, S_CORE_RD, S_CORE_USE,
		S_HEAD_RD, S_HEAD_USE, S_PLACE, S_DONE
	} state_t;

	function automatic logic [31:0] sub_floor(input logic [31:0] a, input logic [31:0] b);
		return (a >= b) ? a - b : 32'd0;
	endfunction

	function automatic logic [31:0] add_sat(input logic [31:0] s, input logic [31:0] d);
		logic [32:0] r;
		r = {1'b0, s} + {1'b0, d};
		return r[32] ? 32'hFFFF_FFFF : r[31:0];
	endfunction

endpackage

// ===== hw/rtl/multicore_job_scheduler.sv =====
// Multi-core job scheduler (FCFS, SJF, PSJF, PRI, PPRI, RR).
// Request channel: present a request and raise start; it is taken at a
// clock edge with start high and busy low. busy stays high until the
// result has been shown.
// Result channel: done is high for exactly one cycle with the result; the
// receiver cannot stall it and must take it in that cycle.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 mode, 1 core count)
// and cfg_data; cfg_ready is low while busy is high.
// Flow: a free-core arrival passes through the dispatch and place states
// before done; the next request is taken from idle after done. Otherwise
// the ready queue memory sets the time: each queue entry searched takes a
// read and a compare state, each entry shifted on insert a read and a write
// state, and each core scanned for a preemption victim a read and a compare
// state. One request at a time.
// Reset: cores idle, queue empty, sums zero, mode FCFS, one core in use.
// The queue is a circular buffer in one memory, the core table another.
module multicore_job_scheduler #(
	parameter int CORES       = mjs_pkg::CORES_DEF,
	parameter int QUEUE_DEPTH = mjs_pkg::QDEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  mjs_pkg::request_t  request,
	output logic               done,
	output mjs_pkg::result_t   result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [3:0]         cfg_data
);

	localparam int CAW = (CORES > 1) ? $clog2(CORES) : 1;
	localparam int CNW = $clog2(CORES + 1);
	localparam int QAW = $clog2(QUEUE_DEPTH);
	localparam int QLW = $clog2(QUEUE_DEPTH + 1);

	mjs_pkg::state_t st_q, st_d;
	mjs_pkg::request_t req_q;
	logic [2:0] mode_q;
	logic [3:0] count_q;
	logic [CORES-1:0] busy_q;

	mjs_pkg::job_t core_mem [CORES];
	mjs_pkg::job_t core_rd, core_wdata;
	logic [CAW-1:0] core_raddr;
	logic core_we;

	mjs_pkg::job_t q_mem [QUEUE_DEPTH];
	mjs_pkg::job_t q_rd, q_wdata;
	logic [QAW-1:0] q_raddr, q_waddr;
	logic q_we;

	logic [QAW-1:0] head_q;
	logic [QLW-1:0] len_q, k_q, pos_q;
	logic [CAW-1:0] scan_q, vcore_q, pcore_q;
	mjs_pkg::job_t vict_q, ins_q, place_q, nj;
	mjs_pkg::job_t vcand, vins;
	logic [15:0] vkey_q;
	logic pend_q;
	logic sched_q, ovf_q;
	logic [2:0] tgt_q;
	logic [15:0] who_q;
	logic [31:0] sum_wait_q, sum_turn_q, sum_resp_q;
	logic [15:0] jobs_q;

	logic [CNW-1:0] n_eff;
	logic bylen, byurg, sorted, pmode;
	logic free_found;
	logic [CAW-1:0] free_idx;
	logic [31:0] t, el, w;
	logic c_ok;
	logic [CAW-1:0] c_addr;
	logic [15:0] rnow, mi, nkey, ek, jk;
	logic better, pre, worse, last;

	function automatic logic [QAW-1:0] qphys(input logic [QAW-1:0] h, input logic [QLW-1:0] k);
		logic [QAW+1:0] s;
		s = (QAW+2)'(h) + (QAW+2)'(k);
		if (s >= (QAW+2)'(QUEUE_DEPTH)) begin
			s = s - (QAW+2)'(QUEUE_DEPTH);
		end
		return QAW'(s);
	endfunction

	always_comb begin
		if (count_q == 4'd0) begin
			n_eff = CNW'(1);
		end else if (int'(count_q) > CORES) begin
			n_eff = CNW'(CORES);
		end else begin
			n_eff = CNW'(count_q);
		end
	end

	assign bylen  = (mode_q == mjs_pkg::MODE_SJF) || (mode_q == mjs_pkg::MODE_PSJF);
	assign byurg  = (mode_q == mjs_pkg::MODE_PRI) || (mode_q == mjs_pkg::MODE_PPRI);
	assign sorted = bylen || byurg;
	assign pmode  = (mode_q == mjs_pkg::MODE_PSJF) || (mode_q == mjs_pkg::MODE_PPRI);

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = CORES - 1; i >= 0; i--) begin
			if (i < int'(n_eff) && !busy_q[i]) begin
				free_found = 1'b1;
				free_idx   = CAW'(i);
			end
		end
	end

	assign t      = req_q.current_time;
	assign c_ok   = int'(req_q.core_index) < CORES;
	assign c_addr = CAW'(req_q.core_index);

	always_comb begin
		nj.num     = req_q.job_id;
		nj.arr     = t;
		nj.rem     = req_q.run_length;
		nj.urg     = req_q.job_priority;
		nj.enq     = t;
		nj.first   = t;
		nj.started = 1'b0;
	end

	assign el     = mjs_pkg::sub_floor(t, core_rd.enq);
	assign rnow   = ({16'd0, core_rd.rem} >= el) ? core_rd.rem - el[15:0] : 16'd0;
	assign mi     = bylen ? rnow : {8'd0, core_rd.urg};
	assign better = (mi == vkey_q) ? (core_rd.arr > vict_q.arr) : (mi > vkey_q);
	assign nkey   = bylen ? req_q.run_length : {8'd0, req_q.job_priority};
	assign pre    = pmode && (vkey_q > nkey);
	assign ek     = bylen ? q_rd.rem : {8'd0, q_rd.urg};
	assign jk     = bylen ? ins_q.rem : {8'd0, ins_q.urg};
	assign worse  = (ek > jk) || ((ek == jk) && (q_rd.arr > ins_q.arr));
	assign last   = (CNW'(scan_q) + CNW'(1)) == n_eff;
	assign w      = mjs_pkg::sub_floor(t, place_q.enq);

	always_comb begin
		vcand     = core_rd;
		vcand.rem = rnow;
		vcand.enq = t;
	end

	always_comb begin
		vins = vict_q;
		if (vict_q.first == t) vins.started = 1'b0;
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			mjs_pkg::S_IDLE:     if (start) st_d = mjs_pkg::S_DISPATCH;
			mjs_pkg::S_DISPATCH: begin
				if (req_q.operation == mjs_pkg::OP_ARRIVE) begin
					if (free_found)  st_d = mjs_pkg::S_PLACE;
					else if (pmode)  st_d = mjs_pkg::S_VS_RD;
					else             st_d = mjs_pkg::S_ARR_DEC;
				end else if ((req_q.operation == mjs_pkg::OP_FINISH ||
				               req_q.operation == mjs_pkg::OP_QUANTUM) &&
				              c_ok && busy_q[c_addr]) begin
					st_d = mjs_pkg::S_CORE_RD;
				end else begin
					st_d = mjs_pkg::S_DONE;
				end
			end
			mjs_pkg::S_VS_RD:    st_d = mjs_pkg::S_VS_CMP;
			mjs_pkg::S_VS_CMP:   st_d = last ? mjs_pkg::S_ARR_DEC : mjs_pkg::S_VS_RD;
			mjs_pkg::S_ARR_DEC:  st_d = (len_q >= QLW'(QUEUE_DEPTH)) ? mjs_pkg::S_DONE
			                                                         : mjs_pkg::S_SRCH;
			mjs_pkg::S_SRCH:     st_d = (k_q == len_q) ? mjs_pkg::S_SRCH_END
			                                           : mjs_pkg::S_SRCH_CMP;
			mjs_pkg::S_SRCH_CMP: st_d = worse ? mjs_pkg::S_SRCH_END : mjs_pkg::S_SRCH;
			mjs_pkg::S_SRCH_END: begin
				if (req_q.operation == mjs_pkg::OP_QUANTUM) begin
					st_d = (k_q == '0) ? mjs_pkg::S_PLACE : mjs_pkg::S_HEAD_RD;
				end else begin
					st_d = mjs_pkg::S_SHIFT;
				end
			end
			mjs_pkg::S_SHIFT:    st_d = (k_q == pos_q) ? mjs_pkg::S_INS_WR : mjs_pkg::S_SHIFT_WR;
			mjs_pkg::S_SHIFT_WR: st_d = mjs_pkg::S_SHIFT;
			mjs_pkg::S_INS_WR:   st_d = pend_q ? mjs_pkg::S_PLACE : mjs_pkg::S_DONE;
			mjs_pkg::S_CORE_RD:  st_d = mjs_pkg::S_CORE_USE;
			mjs_pkg::S_CORE_USE: begin
				if (req_q.operation == mjs_pkg::OP_FINISH) begin
					st_d = (len_q != '0) ? mjs_pkg::S_HEAD_RD : mjs_pkg::S_DONE;
				end else begin
					st_d = mjs_pkg::S_SRCH;
				end
			end
			mjs_pkg::S_HEAD_RD:  st_d = mjs_pkg::S_HEAD_USE;
			mjs_pkg::S_HEAD_USE: st_d = (req_q.operation == mjs_pkg::OP_FINISH)
			                            ? mjs_pkg::S_PLACE : mjs_pkg::S_SHIFT;
			mjs_pkg::S_PLACE:    st_d = mjs_pkg::S_DONE;
			mjs_pkg::S_DONE:     st_d = mjs_pkg::S_IDLE;
			default:             st_d = mjs_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		core_raddr = scan_q;
		core_we    = 1'b0;
		core_wdata = place_q;
		q_raddr    = head_q;
		q_we       = 1'b0;
		q_waddr    = qphys(head_q, k_q);
		q_wdata    = q_rd;
		case (st_q)
			mjs_pkg::S_CORE_RD: core_raddr = c_addr;
			mjs_pkg::S_SRCH:    q_raddr = qphys(head_q, k_q);
			mjs_pkg::S_SHIFT:   q_raddr = qphys(head_q, k_q - QLW'(1));
			mjs_pkg::S_SHIFT_WR: q_we = 1'b1;
			mjs_pkg::S_INS_WR: begin
				q_we    = 1'b1;
				q_waddr = qphys(head_q, pos_q);
				q_wdata = ins_q;
			end
			mjs_pkg::S_PLACE: begin
				core_we            = 1'b1;
				core_wdata.enq     = t;
				core_wdata.first   = place_q.started ? place_q.first : t;
				core_wdata.started = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (core_we) begin
			core_mem[pcore_q] <= core_wdata;
		end
		core_rd <= core_mem[core_raddr];
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			q_mem[q_waddr] <= q_wdata;
		end
		q_rd <= q_mem[q_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= mjs_pkg::S_IDLE;
			mode_q     <= mjs_pkg::MODE_FCFS;
			count_q    <= 4'd1;
			busy_q     <= '0;
			head_q     <= '0;
			len_q      <= '0;
			sched_q    <= 1'b0;
			ovf_q      <= 1'b0;
			sum_wait_q <= '0;
			sum_turn_q <= '0;
			sum_resp_q <= '0;
			jobs_q     <= '0;
		end else begin
			st_q <= st_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == mjs_pkg::REG_MODE) mode_q <= cfg_data[2:0];
				else                                count_q <= cfg_data;
			end
			case (st_q)
				mjs_pkg::S_IDLE: begin
					if (start) begin
						sched_q <= 1'b0;
						ovf_q   <= 1'b0;
					end
				end
				mjs_pkg::S_ARR_DEC: begin
					if (len_q >= QLW'(QUEUE_DEPTH)) ovf_q <= 1'b1;
				end
				mjs_pkg::S_CORE_USE: begin
					if (req_q.operation == mjs_pkg::OP_FINISH) begin
						if (jobs_q != 16'hFFFF) jobs_q <= jobs_q + 16'd1;
						sum_turn_q <= mjs_pkg::add_sat(sum_turn_q,
						                               mjs_pkg::sub_floor(t, core_rd.arr));
						busy_q[c_addr] <= 1'b0;
					end
				end
				mjs_pkg::S_HEAD_USE: begin
					head_q <= qphys(head_q, QLW'(1));
					len_q  <= len_q - QLW'(1);
				end
				mjs_pkg::S_INS_WR: len_q <= len_q + QLW'(1);
				mjs_pkg::S_PLACE: begin
					sum_wait_q <= mjs_pkg::add_sat(sum_wait_q, w);
					if (!place_q.started) sum_resp_q <= mjs_pkg::add_sat(sum_resp_q, w);
					busy_q[pcore_q] <= 1'b1;
					sched_q         <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			mjs_pkg::S_IDLE: begin
				if (start) begin
					req_q <= request;
					tgt_q <= 3'd0;
					who_q <= 16'd0;
				end
			end
			mjs_pkg::S_DISPATCH: begin
				place_q <= nj;
				pcore_q <= free_idx;
				scan_q  <= '0;
			end
			mjs_pkg::S_VS_CMP: begin
				if (scan_q == '0 || better) begin
					vict_q  <= vcand;
					vkey_q  <= mi;
					vcore_q <= scan_q;
				end
				scan_q <= scan_q + CAW'(1);
			end
			mjs_pkg::S_ARR_DEC: begin
				if (pre) begin
					ins_q   <= vins;
					place_q <= nj;
					pcore_q <= vcore_q;
					pend_q  <= 1'b1;
				end else begin
					ins_q  <= nj;
					pend_q <= 1'b0;
				end
				k_q <= sorted ? '0 : len_q;
			end
			mjs_pkg::S_SRCH_CMP: if (!worse) k_q <= k_q + QLW'(1);
			mjs_pkg::S_SRCH_END: begin
				pos_q <= k_q;
				k_q   <= len_q;
				if (req_q.operation == mjs_pkg::OP_QUANTUM && k_q == '0) place_q <= ins_q;
			end
			mjs_pkg::S_SHIFT_WR: k_q <= k_q - QLW'(1);
			mjs_pkg::S_CORE_USE: begin
				pcore_q <= c_addr;
				ins_q   <= vcand;
				k_q     <= sorted ? '0 : len_q;
			end
			mjs_pkg::S_HEAD_USE: begin
				place_q <= q_rd;
				pos_q   <= pos_q - QLW'(1);
				k_q     <= len_q - QLW'(1);
				pend_q  <= 1'b1;
			end
			mjs_pkg::S_PLACE: begin
				tgt_q <= 3'(pcore_q);
				who_q <= place_q.num;
			end
			default: ;
		endcase
	end

	assign busy      = st_q != mjs_pkg::S_IDLE;
	assign done      = st_q == mjs_pkg::S_DONE;
	assign cfg_ready = !busy;

	always_comb begin
		result.scheduled        = sched_q;
		result.target_core      = tgt_q;
		result.started_job      = who_q;
		result.queue_overflow   = ovf_q;
		result.total_waiting    = sum_wait_q;
		result.total_turnaround = sum_turn_q;
		result.total_response   = sum_resp_q;
		result.finished_count   = jobs_q;
	end

`ifndef NO_ASSERTIONS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= QLW'(QUEUE_DEPTH)) else $error("queue length beyond depth");
	a_ovf_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.scheduled && result.queue_overflow))
		else $error("overflow with assignment");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done)) else $error("request not taken");
	a_len_step: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == mjs_pkg::S_INS_WR) |=> (len_q == $past(len_q) + QLW'(1)))
		else $error("insert did not grow queue");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import mjs_pkg::*;

	localparam int NCORES     = CORES_DEF;
	localparam int QCAP       = QDEPTH_DEF;
	localparam int DRAIN_WAIT = 4 * QDEPTH_DEF + 2 * CORES_DEF + 40;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	request_t   request;
	logic       done;
	result_t    result;
	logic       cfg_valid;
	logic       cfg_ready;
	logic       cfg_index;
	logic [3:0] cfg_data;

	multicore_job_scheduler DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// scheduler mirror
	logic [2:0]  mir_mode;
	logic [3:0]  mir_count;
	logic        mir_busy [NCORES];
	job_t        mir_core [NCORES];
	job_t        mir_queue [$];
	logic [31:0] mir_wait, mir_turn, mir_resp;
	logic [15:0] mir_done;

	result_t     pending_results [$];
	int          errors, checked, sent, overflows, preempts;
	bit          no_gaps;
	logic [31:0] clock_now;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("status: fail");
		$finish;
	end

	function automatic logic [31:0] diff_floor(logic [31:0] a, logic [31:0] b);
		return (a < b) ? 32'd0 : a - b;
	endfunction

	function automatic logic [31:0] sum_clip(logic [31:0] s, logic [31:0] d);
		logic [32:0] w;
		w = {1'b0, s} + {1'b0, d};
		return w[32] ? '1 : w[31:0];
	endfunction

	function automatic bit by_length();
		return mir_mode == MODE_SJF || mir_mode == MODE_PSJF;
	endfunction

	function automatic bit by_urgency();
		return mir_mode == MODE_PRI || mir_mode == MODE_PPRI;
	endfunction

	function automatic int queue_slot(job_t j);
		logic [15:0] nk, ek;
		if (!by_length() && !by_urgency())
			return mir_queue.size();
		nk = by_length() ? j.rem : {8'd0, j.urg};
		for (int k = 0; k < mir_queue.size(); k++) begin
			ek = by_length() ? mir_queue[k].rem : {8'd0, mir_queue[k].urg};
			if (ek > nk || (ek == nk && mir_queue[k].arr > j.arr))
				return k;
		end
		return mir_queue.size();
	endfunction

	function automatic logic [15:0] left_on_core(int c, logic [31:0] t);
		return 16'(diff_floor({16'd0, mir_core[c].rem}, diff_floor(t, mir_core[c].enq)));
	endfunction

	// enq of a core entry holds its start time
	function automatic void run_on_core(int c, job_t j, logic [31:0] t);
		logic [31:0] w;
		w = diff_floor(t, j.enq);
		mir_wait = sum_clip(mir_wait, w);
		if (!j.started) begin
			mir_resp = sum_clip(mir_resp, w);
			j.first = t;
			j.started = 1'b1;
		end
		j.enq = t;
		mir_core[c] = j;
		mir_busy[c] = 1'b1;
	endfunction

	function automatic result_t schedule_event(request_t r);
		result_t     o;
		job_t        nj, v;
		int          n, i, f, pos;
		logic [31:0] mf, mi, t;
		bit          pre;
		o = '0;
		t = r.current_time;
		n = (mir_count == 0) ? 1 : (mir_count > NCORES ? NCORES : mir_count);
		if (r.operation == OP_ARRIVE) begin
			nj = '{num: r.job_id, arr: t, rem: r.run_length, urg: r.job_priority,
				enq: t, first: t, started: 1'b0};
			i = 0;
			while (i < n && mir_busy[i])
				i++;
			if (i < n) begin
				run_on_core(i, nj, t);
				o.scheduled = 1'b1;
				o.target_core = 3'(i);
				o.started_job = nj.num;
			end else begin
				pre = 1'b0;
				f = 0;
				if (mir_mode == MODE_PSJF || mir_mode == MODE_PPRI) begin
					mf = (mir_mode == MODE_PSJF) ? left_on_core(0, t) : mir_core[0].urg;
					for (i = 1; i < n; i++) begin
						mi = (mir_mode == MODE_PSJF) ? left_on_core(i, t) : mir_core[i].urg;
						if (mi == mf ? mir_core[i].arr > mir_core[f].arr : mi > mf) begin
							f = i;
							mf = mi;
						end
					end
					pre = mf > ((mir_mode == MODE_PSJF) ? {16'd0, nj.rem} : {24'd0, nj.urg});
				end
				if (mir_queue.size() >= QCAP) begin
					o.queue_overflow = 1'b1;
				end else if (pre) begin
					v = mir_core[f];
					v.rem = left_on_core(f, t);
					v.enq = t;
					if (v.first == t)
						v.started = 1'b0;
					mir_queue.insert(queue_slot(v), v);
					run_on_core(f, nj, t);
					o.scheduled = 1'b1;
					o.target_core = 3'(f);
					o.started_job = nj.num;
					preempts++;
				end else begin
					mir_queue.insert(queue_slot(nj), nj);
				end
			end
		end else if ((r.operation == OP_FINISH || r.operation == OP_QUANTUM)
				&& mir_busy[r.core_index]) begin
			i = r.core_index;
			if (r.operation == OP_FINISH) begin
				if (mir_done != 16'hFFFF)
					mir_done++;
				mir_turn = sum_clip(mir_turn, diff_floor(t, mir_core[i].arr));
				mir_busy[i] = 1'b0;
				if (mir_queue.size() > 0) begin
					v = mir_queue.pop_front();
					run_on_core(i, v, t);
					o.scheduled = 1'b1;
					o.target_core = 3'(i);
					o.started_job = v.num;
				end
			end else begin
				v = mir_core[i];
				v.rem = left_on_core(i, t);
				v.enq = t;
				pos = queue_slot(v);
				if (pos == 0) begin
					run_on_core(i, v, t);
					o.started_job = v.num;
				end else begin
					nj = mir_queue.pop_front();
					mir_queue.insert(pos - 1, v);
					run_on_core(i, nj, t);
					o.started_job = nj.num;
				end
				o.scheduled = 1'b1;
				o.target_core = 3'(i);
			end
		end
		o.total_waiting = mir_wait;
		o.total_turnaround = mir_turn;
		o.total_response = mir_resp;
		o.finished_count = mir_done;
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch on result %0d: %s got %0h expected %0h", checked, what, got, want);
	endtask

	always @(negedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 32'd1, 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (result.scheduled !== want.scheduled)
					report_mismatch("scheduled", result.scheduled, want.scheduled);
				if (result.target_core !== want.target_core)
					report_mismatch("target_core", result.target_core, want.target_core);
				if (result.started_job !== want.started_job)
					report_mismatch("started_job", result.started_job, want.started_job);
				if (result.queue_overflow !== want.queue_overflow)
					report_mismatch("queue_overflow", result.queue_overflow, want.queue_overflow);
				if (result.total_waiting !== want.total_waiting)
					report_mismatch("total_waiting", result.total_waiting, want.total_waiting);
				if (result.total_turnaround !== want.total_turnaround)
					report_mismatch("total_turnaround", result.total_turnaround,
						want.total_turnaround);
				if (result.total_response !== want.total_response)
					report_mismatch("total_response", result.total_response, want.total_response);
				if (result.finished_count !== want.finished_count)
					report_mismatch("finished_count", result.finished_count, want.finished_count);
				if (want.queue_overflow)
					overflows++;
				checked++;
			end
		end
	end

	// called just after a rising edge; start stays high when no gap follows
	task automatic send_request(request_t r);
		int gap;
		request <= r;
		start <= 1'b1;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
		pending_results.push_back(schedule_event(r));
		sent++;
		gap = no_gaps ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [3:0] val);
		drain_results();
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_MODE)
			mir_mode = val[2:0];
		else
			mir_count = val;
	endtask

	function automatic request_t make_request(logic [1:0] op, logic [15:0] id,
			logic [31:0] t, logic [15:0] len, logic [7:0] pri, logic [2:0] core);
		request_t r;
		r.operation = op;
		r.job_id = id;
		r.current_time = t;
		r.run_length = len;
		r.job_priority = pri;
		r.core_index = core;
		return r;
	endfunction

	function automatic request_t random_request(bit wide);
		request_t r;
		int       p;
		p = $urandom_range(0, 99);
		r.operation = (p < 45) ? OP_ARRIVE : (p < 72) ? OP_FINISH : (p < 96) ? OP_QUANTUM : OP_NONE;
		r.job_id = 16'($urandom);
		if (wide)
			clock_now = $urandom;
		else if ($urandom_range(0, 29) == 0)
			clock_now = clock_now - $urandom_range(0, 60);
		else
			clock_now = clock_now + $urandom_range(0, 25);
		r.current_time = clock_now;
		r.run_length = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
			: 16'($urandom_range(1, 40));
		r.job_priority = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
		r.core_index = 3'($urandom_range(0, 7));
		return r;
	endfunction

	task automatic test_field_extremes();
		write_reg(REG_MODE, MODE_FCFS);
		write_reg(REG_CORES, 4'd1);
		send_request(make_request(OP_FINISH, 16'd0, 32'd0, 16'd1, 8'd0, 3'd0));
		send_request(make_request(OP_QUANTUM, 16'd0, 32'd1, 16'd1, 8'd0, 3'd7));
		send_request(make_request(OP_NONE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 3'd7));
		send_request(make_request(OP_ARRIVE, 16'd0, 32'd0, 16'd1, 8'd0, 3'd0));
		send_request(make_request(OP_ARRIVE, 16'hFFFF, 32'd3, 16'hFFFF, 8'hFF, 3'd7));
		send_request(make_request(OP_QUANTUM, 16'd0, 32'd5, 16'd1, 8'd0, 3'd0));
		send_request(make_request(OP_QUANTUM, 16'd0, 32'd2, 16'd1, 8'd0, 3'd0));
		send_request(make_request(OP_FINISH, 16'd0, 32'd1, 16'd1, 8'd0, 3'd0));
		send_request(make_request(OP_FINISH, 16'd0, 32'd9, 16'd1, 8'd0, 3'd0));
		write_reg(REG_MODE, 3'd7);
		write_reg(REG_CORES, 4'd0);
		send_request(make_request(OP_ARRIVE, 16'd5, 32'd10, 16'd4, 8'd3, 3'd0));
		send_request(make_request(OP_ARRIVE, 16'd6, 32'd11, 16'd2, 8'd1, 3'd0));
		send_request(make_request(OP_FINISH, 16'd0, 32'd12, 16'd1, 8'd0, 3'd1));
		send_request(make_request(OP_FINISH, 16'd0, 32'd13, 16'd1, 8'd0, 3'd0));
		send_request(make_request(OP_FINISH, 16'd0, 32'd14, 16'd1, 8'd0, 3'd0));
		write_reg(REG_MODE, MODE_PPRI);
		write_reg(REG_CORES, 4'd15);
		for (int k = 0; k < 9; k++)
			send_request(make_request(OP_ARRIVE, 16'(100 + k), 32'd20, 16'd7, 8'(9 - k), 3'd0));
		send_request(make_request(OP_ARRIVE, 16'd200, 32'd20, 16'd7, 8'd0, 3'd0));
		send_request(make_request(OP_QUANTUM, 16'd0, 32'd30, 16'd1, 8'd0, 3'd6));
		for (int k = 0; k < 8; k++)
			send_request(make_request(OP_FINISH, 16'd0, 32'd40, 16'd1, 8'd0, 3'(k)));
		drain_results();
	endtask

	task automatic test_full_queue();
		write_reg(REG_MODE, MODE_PSJF);
		write_reg(REG_CORES, 4'd1);
		no_gaps = 1'b1;
		for (int k = 0; k < QCAP + 1; k++)
			send_request(make_request(OP_ARRIVE, 16'(300 + k), 32'(100 + k), 16'd500, 8'd0, 3'd0));
		no_gaps = 1'b0;
		send_request(make_request(OP_ARRIVE, 16'd999, 32'd200, 16'd500, 8'd0, 3'd0));
		send_request(make_request(OP_ARRIVE, 16'd998, 32'd201, 16'd1, 8'd0, 3'd0));
		send_request(make_request(OP_QUANTUM, 16'd0, 32'd202, 16'd1, 8'd0, 3'd0));
		for (int k = 0; k < QCAP + 1; k++)
			send_request(make_request(OP_FINISH, 16'd0, 32'(300 + k), 16'd1, 8'd0, 3'd0));
		drain_results();
	endtask

	task automatic test_random_mode(logic [2:0] m, logic [3:0] cnt, int items);
		write_reg(REG_MODE, m);
		write_reg(REG_CORES, cnt);
		for (int k = 0; k < items; k++) begin
			if (k % 40 == 0)
				no_gaps = $urandom_range(0, 2) == 0;
			send_request(random_request(1'b0));
		end
		drain_results();
	endtask

	task automatic test_time_wrap();
		write_reg(REG_MODE, MODE_RR);
		write_reg(REG_CORES, 4'd8);
		for (int k = 0; k < 60; k++)
			send_request(random_request(1'b1));
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_valid = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		errors = 0;
		checked = 0;
		sent = 0;
		overflows = 0;
		preempts = 0;
		no_gaps = 1'b0;
		clock_now = 32'd1000;
		mir_mode = MODE_FCFS;
		mir_count = 4'd1;
		mir_wait = '0;
		mir_turn = '0;
		mir_resp = '0;
		mir_done = '0;
		foreach (mir_busy[k]) begin
			mir_busy[k] = 1'b0;
			mir_core[k] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_full_queue();
		test_random_mode(MODE_FCFS, 4'd3, 60);
		test_random_mode(MODE_SJF, 4'd2, 60);
		test_random_mode(MODE_PSJF, 4'd4, 70);
		test_random_mode(MODE_PRI, 4'd1, 50);
		test_random_mode(MODE_PPRI, 4'd8, 70);
		test_random_mode(MODE_RR, 4'd5, 60);
		test_random_mode(3'd6, 4'd12, 40);
		test_random_mode(MODE_PSJF, 4'd0, 40);
		test_time_wrap();

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("%0d requests over all modes and core counts, %0d results checked",
			sent, checked);
		$display("%0d dropped on a full queue, %0d preemptions", overflows, preempts);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/mjs_pkg.sv
hw/rtl/multicore_job_scheduler.sv
tb/tb.sv
